// File: hw/rtl/piu_pkg.sv
// Package for the paletted index unpacker: shared types, op codes, widths
// and small helper functions for entry width handling.
// No dependencies.
package piu_pkg;

  localparam int WORD_W    = 64;
  localparam int ID_W      = 32;
  localparam int IDX_W     = 12;
  localparam int WIDTH_W   = 6;
  localparam int FCNT_W    = 5;
  localparam int SLOT_W    = 8;
  localparam int PAL_IDX_W = 8;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd4;
  localparam logic [WIDTH_W-1:0] MIN_WIDTH   = 6'd4;
  localparam logic [WIDTH_W-1:0] DIRECT_MIN  = 6'd9;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_PAL_WR = 2'd1,
    OP_DATA   = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic ld_word;
    logic pal_wr;
    logic clr_cnt;
    logic adv;
  } piu_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_field;
  } piu_stat_t;

  // Widths below four behave as four.
  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
    return (w < MIN_WIDTH) ? MIN_WIDTH : w;
  endfunction

  // Number of whole fields of width w in one 64-bit word, for w from 4 to 63.
  function automatic logic [FCNT_W-1:0] field_count(input logic [WIDTH_W-1:0] w);
    logic [FCNT_W-1:0] n;
    priority if (w <= 6'd4)  n = 5'd16;
    else if (w == 6'd5)      n = 5'd12;
    else if (w == 6'd6)      n = 5'd10;
    else if (w == 6'd7)      n = 5'd9;
    else if (w == 6'd8)      n = 5'd8;
    else if (w == 6'd9)      n = 5'd7;
    else if (w == 6'd10)     n = 5'd6;
    else if (w <= 6'd12)     n = 5'd5;
    else if (w <= 6'd16)     n = 5'd4;
    else if (w <= 6'd21)     n = 5'd3;
    else if (w <= 6'd32)     n = 5'd2;
    else                     n = 5'd1;
    return n;
  endfunction

  // Mask of the low w bits, saturating at the full id width.
  function automatic logic [ID_W-1:0] id_mask(input logic [WIDTH_W-1:0] w);
    logic [ID_W-1:0] m;
    if (w >= 6'd32) begin
      m = '1;
    end else begin
      m = (32'd1 << w[4:0]) - 32'd1;
    end
    return m;
  endfunction

endpackage

// File: hw/rtl/piu_stream_ifs.sv
// Valid/ready channel interfaces for the paletted index unpacker: the input
// word channel and the result channel. Depends on piu_pkg for field widths.
interface piu_in_if import piu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [SLOT_W-1:0]    palette_slot;
  logic [ID_W-1:0]      palette_value;
  logic [WORD_W-1:0]    data_word;

  modport source (output valid, op, palette_slot, palette_value, data_word, input ready);
  modport sink   (input valid, op, palette_slot, palette_value, data_word, output ready);
endinterface

interface piu_out_if import piu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  blk_pos;
  logic [ID_W-1:0]   block_id;
  logic              overflow;
  logic              last;

  modport source (output valid, blk_pos, block_id, overflow, last, input ready);
  modport sink   (input valid, blk_pos, block_id, overflow, last, output ready);
endinterface

// File: hw/rtl/piu_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module piu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/piu_ctrl.sv
// Controller for the paletted index unpacker: accepts words and sequences
// the field walk of a data word. Depends on piu_pkg.
module piu_ctrl import piu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_op,
  output logic      in_ready,
  input  piu_stat_t stat,
  output piu_cmd_t  cmd
);

  state_t state_r, state_nxt;
  op_t    op;

  assign op = op_t'(in_op);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && op == OP_DATA) begin
          state_nxt = ST_PRIME;
        end
      end
      // Waits for the palette read of the first field.
      ST_PRIME: state_nxt = ST_RUN;
      ST_RUN: begin
        if (stat.out_free && stat.last_field) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.ld_word = in_valid && op == OP_DATA;
        cmd.pal_wr  = in_valid && op == OP_PAL_WR;
        cmd.clr_cnt = in_valid && op == OP_START;
      end
      ST_PRIME: begin
      end
      ST_RUN: begin
        cmd.adv = stat.out_free;
      end
      default: begin
      end
    endcase
  end

  a_ld_primes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_word |=> state_r == ST_PRIME)
    else $error("data word accepted without priming the palette read");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.adv && stat.last_field) |=> state_r == ST_IDLE)
    else $error("controller did not return to idle after the last field");

  a_no_adv_prime: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PRIME |-> !cmd.adv)
    else $error("field advanced before its palette read was ready");

endmodule

// File: hw/rtl/piu_datapath.sv
// Datapath for the paletted index unpacker: width register, word shifter,
// palette RAM, block counter and the result register. Depends on piu_pkg
// and piu_ram.
module piu_datapath import piu_pkg::*; #(
  parameter int PALETTE_DEPTH  = 256,
  parameter int SECTION_BLOCKS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  piu_cmd_t           cmd,
  output piu_stat_t          stat,
  input  logic               cfg_we,
  input  logic [WIDTH_W-1:0] cfg_wdata,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [ID_W-1:0]    in_value,
  input  logic [WORD_W-1:0]  in_word,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [IDX_W-1:0]   out_blk_pos,
  output logic [ID_W-1:0]    out_block_id,
  output logic               out_overflow,
  output logic               out_last
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(SECTION_BLOCKS) + 1;
  localparam logic [CW-1:0]        SECTION_LIMIT = CW'(SECTION_BLOCKS);
  localparam logic [PAL_IDX_W:0]   PAL_LIMIT     = (PAL_IDX_W + 1)'(PALETTE_DEPTH);

  logic [WIDTH_W-1:0] width_r, width_nxt;
  logic [WIDTH_W-1:0] eff_r, eff_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;
  logic [FCNT_W-1:0]  remaining_r, remaining_nxt;
  logic [CW-1:0]      counter_r, counter_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]   index_r;
  logic [ID_W-1:0]    id_r;
  logic               ovf_r;
  logic               last_r;

  logic [WORD_W-1:0]    next_word;
  logic [ID_W-1:0]      width_mask;
  logic [PAL_IDX_W-1:0] idx_mask;
  logic [PAL_IDX_W-1:0] cur_idx;
  logic [PAL_IDX_W-1:0] nxt_idx;
  logic [AW-1:0]        rd_addr;
  logic [ID_W-1:0]      rd_data;
  logic                 wr_en;
  logic                 pal_mode;
  logic                 in_range;
  logic                 full;
  logic [ID_W-1:0]      field_id;

  assign next_word  = word_r >> eff_r;
  assign width_mask = id_mask(eff_r);
  assign idx_mask   = width_mask[PAL_IDX_W-1:0];
  assign cur_idx    = word_r[PAL_IDX_W-1:0] & idx_mask;
  assign nxt_idx    = next_word[PAL_IDX_W-1:0] & idx_mask;
  // While advancing, read ahead for the field that comes next so that the
  // registered read data always belongs to the field in word_r.
  assign rd_addr   = cmd.adv ? AW'(nxt_idx) : AW'(cur_idx);
  assign wr_en     = cmd.pal_wr && ({1'b0, in_slot} < PAL_LIMIT);

  piu_ram #(
    .WIDTH (ID_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(in_slot)),
    .wdata (in_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign pal_mode = eff_r < DIRECT_MIN;
  assign in_range = {1'b0, cur_idx} < PAL_LIMIT;
  assign full     = counter_r >= SECTION_LIMIT;

  always_comb begin
    if (pal_mode) begin
      field_id = in_range ? rd_data : '0;
    end else begin
      field_id = word_r[ID_W-1:0] & width_mask;
    end
  end

  always_comb begin
    width_nxt     = cfg_we ? cfg_wdata : width_r;
    eff_nxt       = eff_r;
    word_nxt      = word_r;
    remaining_nxt = remaining_r;
    counter_nxt   = counter_r;
    if (cmd.ld_word) begin
      eff_nxt       = eff_width(width_r);
      word_nxt      = in_word;
      remaining_nxt = field_count(eff_width(width_r));
    end
    if (cmd.adv) begin
      word_nxt      = next_word;
      remaining_nxt = remaining_r - 1'b1;
      if (!full) begin
        counter_nxt = counter_r + 1'b1;
      end
    end
    if (cmd.clr_cnt) begin
      counter_nxt = '0;
    end
    out_valid_nxt = cmd.adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RESET;
      remaining_r <= '0;
      counter_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      remaining_r <= remaining_nxt;
      counter_r   <= counter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eff_r  <= eff_nxt;
    word_r <= word_nxt;
    if (cmd.adv) begin
      index_r <= full ? '0 : IDX_W'(counter_r);
      id_r    <= full ? '0 : field_id;
      ovf_r   <= full;
      last_r  <= remaining_r == FCNT_W'(1);
    end
  end

  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.last_field = remaining_r == FCNT_W'(1);

  assign out_valid       = out_valid_r;
  assign out_blk_pos     = index_r;
  assign out_block_id    = id_r;
  assign out_overflow    = ovf_r;
  assign out_last        = last_r;

  a_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    counter_r <= SECTION_LIMIT)
    else $error("block counter ran past the section size");

  a_load_fields: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_word |=> remaining_r != '0)
    else $error("data word loaded with no fields to walk");

  a_adv_fields: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.adv |-> remaining_r != '0)
    else $error("field advanced past the end of the word");

endmodule

// File: hw/rtl/paletted_index_unpacker.sv
// Top level of the paletted index unpacker: joins controller and datapath.
// Depends on piu_pkg, piu_in_if/piu_out_if, piu_ctrl and piu_datapath.
//
// Usage:
//   in_ch carries one word per handshake: op selects start of section,
//   palette entry write, or a 64-bit packed data word. out_ch carries one
//   word per decoded field: blk_pos, block_id, overflow and last.
//   cfg_we/cfg_wdata write the entry width register while the block is idle.
// Timing:
//   A data word of width b yields n = floor(64/b) results (16 at most). After
//   it is accepted, the block first primes the palette RAM read of the first
//   field, then walks one field per cycle through the registered RAM read
//   port while out_ch can take each result.
// Reset:
//   The width register returns to 4 and the block counter to zero. Palette
//   contents are kept; an entry reads as undefined until written.
// Stalls:
//   While a result waits with out_ch.ready low the result register holds and
//   the walk pauses; in_ch.ready stays low until the last field is registered.
module paletted_index_unpacker import piu_pkg::*; #(
  parameter int PALETTE_DEPTH  = 256,
  parameter int SECTION_BLOCKS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  piu_in_if.sink             in_ch,
  piu_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [WIDTH_W-1:0] cfg_wdata
);

  piu_cmd_t  cmd;
  piu_stat_t stat;

  piu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  piu_datapath #(
    .PALETTE_DEPTH  (PALETTE_DEPTH),
    .SECTION_BLOCKS (SECTION_BLOCKS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_slot         (in_ch.palette_slot),
    .in_value        (in_ch.palette_value),
    .in_word         (in_ch.data_word),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_blk_pos     (out_ch.blk_pos),
    .out_block_id    (out_ch.block_id),
    .out_overflow    (out_ch.overflow),
    .out_last        (out_ch.last)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for paletted_index_unpacker: drives section, palette and data words,
// predicts every decoded field and checks the result stream in order.
// Depends on piu_pkg, piu_in_if/piu_out_if and the paletted_index_unpacker RTL.
import piu_pkg::*;

typedef struct packed {
  logic [IDX_W-1:0] index;
  logic [ID_W-1:0]  id;
  logic             ovf;
  logic             last;
} field_result_t;

class unpack_scoreboard;
  localparam int PAL_DEPTH     = 256;
  localparam int SECTION_LIMIT = 4096;

  logic [ID_W-1:0]    palette [PAL_DEPTH];
  bit                 written [PAL_DEPTH];
  logic [12:0]        blk_cnt;
  logic [WIDTH_W-1:0] width_reg;
  field_result_t      fields_q[$];
  int                 errors;
  int                 words_seen;
  int                 fields_checked;
  int                 overflow_fields;

  function new();
    blk_cnt         = '0;
    width_reg       = WIDTH_RESET;
    errors          = 0;
    words_seen      = 0;
    fields_checked  = 0;
    overflow_fields = 0;
    foreach (written[i]) written[i] = 1'b0;
  endfunction

  function void set_width(logic [WIDTH_W-1:0] w);
    width_reg = w;
  endfunction

  function int pending();
    return fields_q.size();
  endfunction

  // Works out every field that an accepted input word will produce.
  function void note_input(op_t op, logic [SLOT_W-1:0] slot, logic [ID_W-1:0] value,
                           logic [WORD_W-1:0] word);
    int b;
    int n;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] field;
    field_result_t r;
    words_seen++;
    case (op)
      OP_START: begin
        blk_cnt = '0;
      end
      OP_PAL_WR: begin
        palette[slot] = value;
        written[slot] = 1'b1;
      end
      OP_DATA: begin
        b = (width_reg < MIN_WIDTH) ? int'(MIN_WIDTH) : int'(width_reg);
        n = WORD_W / b;
        mask = (64'd1 << b) - 64'd1;
        for (int j = 0; j < n; j++) begin
          field = (word >> (j * b)) & mask;
          if (blk_cnt >= SECTION_LIMIT) begin
            r.index = '0;
            r.id    = '0;
            r.ovf   = 1'b1;
            overflow_fields++;
          end else begin
            r.index = blk_cnt[IDX_W-1:0];
            r.id    = (b <= 8) ? palette[field[PAL_IDX_W-1:0]] : field[ID_W-1:0];
            r.ovf   = 1'b0;
            blk_cnt = blk_cnt + 13'd1;
          end
          r.last = (j == n - 1);
          fields_q.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [IDX_W-1:0] index, logic [ID_W-1:0] id, logic ovf,
                             logic last);
    field_result_t e;
    if (fields_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected field: index %0d id %h ovf %b last %b",
                 index, id, ovf, last);
      return;
    end
    e = fields_q.pop_front();
    fields_checked++;
    if (index !== e.index || id !== e.id || ovf !== e.ovf || last !== e.last) begin
      errors++;
      if (errors <= 10)
        $display("field %0d mismatch: expected index %0d id %h ovf %b last %b, %s",
                 fields_checked, e.index, e.id, e.ovf, e.last,
                 $sformatf("got index %0d id %h ovf %b last %b", index, id, ovf, last));
    end
  endfunction

  function void close_out();
    errors += fields_q.size();
  endfunction
endclass

module testbench;
  localparam int PAL_DEPTH     = 256;
  localparam int SECTION_LIMIT = 4096;
  localparam int HOLD_CYCLES   = 150;
  localparam logic [WIDTH_W-1:0] PHASE_WIDTHS [16] = '{
    6'd5, 6'd6, 6'd7, 6'd8, 6'd2, 6'd9, 6'd10, 6'd12,
    6'd16, 6'd17, 6'd21, 6'd22, 6'd31, 6'd40, 6'd0, 6'd3
  };

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [WIDTH_W-1:0] cfg_wdata;
  bit                 src_idle_on;
  bit                 sink_idle_on;
  bit                 hold_request;
  int                 widths_written;

  piu_in_if  in_if ();
  piu_out_if out_if ();

  unpack_scoreboard sb = new();

  paletted_index_unpacker #(
    .PALETTE_DEPTH (PAL_DEPTH),
    .SECTION_BLOCKS(SECTION_LIMIT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SLOT_W-1:0] rand_slot();
    return SLOT_W'($urandom);
  endfunction

  // In palette mode every field must select an entry that was already written.
  function automatic logic [WORD_W-1:0] next_data_word();
    int b;
    int n;
    int cand[$];
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] f;
    b = (sb.width_reg < MIN_WIDTH) ? int'(MIN_WIDTH) : int'(sb.width_reg);
    w = rand_word();
    if (b > 8) begin
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 1) ? '1 : '0;
      return w;
    end
    for (int s = 0; s < (1 << b); s++)
      if (sb.written[s]) cand.push_back(s);
    n = WORD_W / b;
    mask = (64'd1 << b) - 64'd1;
    for (int j = 0; j < n; j++) begin
      f = WORD_W'(cand[$urandom_range(0, cand.size() - 1)]);
      w = (w & ~(mask << (j * b))) | (f << (j * b));
    end
    return w;
  endfunction

  task automatic sender_gap();
    if (src_idle_on && $urandom_range(0, 99) < 25) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_item(input op_t op, input logic [SLOT_W-1:0] slot,
                           input logic [ID_W-1:0] value, input logic [WORD_W-1:0] word);
    in_if.valid         <= 1'b1;
    in_if.op            <= op;
    in_if.palette_slot  <= slot;
    in_if.palette_value <= value;
    in_if.data_word     <= word;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(op, slot, value, word);
    sender_gap();
  endtask

  task automatic send_data(input logic [WORD_W-1:0] word);
    send_item(OP_DATA, rand_slot(), $urandom, word);
  endtask

  // The width register may only change once the block has gone quiet.
  task automatic set_width(input logic [WIDTH_W-1:0] w);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wdata <= w;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_width(w);
    widths_written++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.blk_pos, out_if.block_id, out_if.overflow, out_if.last);
  end

  // Result side: random back-pressure bursts, plus one long hold on request.
  initial begin
    out_if.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_idle_on && $urandom_range(0, 99) < 20) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int pick;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_if.valid         = 1'b0;
    in_if.op            = OP_START;
    in_if.palette_slot  = '0;
    in_if.palette_value = '0;
    in_if.data_word     = '0;
    src_idle_on         = 1'b1;
    sink_idle_on        = 1'b1;
    hold_request        = 1'b0;
    widths_written      = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset width of four.
    send_item(OP_START, '0, '0, '0);
    send_item(OP_PAL_WR, 8'd0, 32'h0000_0000, '0);
    send_item(OP_PAL_WR, 8'd15, 32'hFFFF_FFFF, '1);
    send_item(OP_PAL_WR, 8'd255, 32'h5A5A_C3C3, rand_word());
    send_item(OP_PAL_WR, 8'd7, $urandom, rand_word());
    send_data(64'h0);
    send_data('1);
    send_data(64'hF0F0_F0F0_F0F0_F0F0);
    send_item(OP_RSVD, '1, '1, '1);

    set_width(6'd8);
    send_data(64'hFF00_FF00_FF00_FF00);
    send_data('1);

    set_width(6'd32);
    send_data('1);
    send_data(rand_word());

    // Over 32 bits wide: one field per word, only its low 32 bits survive.
    set_width(6'd63);
    send_data('1);
    send_data(64'h8000_0000_0000_0000);

    set_width(6'd9);
    send_data(rand_word());

    set_width(6'd0);
    send_data(64'h0);

    set_width(6'd1);
    send_data('1);
    send_item(OP_START, rand_slot(), $urandom, rand_word());
    send_data(64'hF0F0_F0F0_F0F0_F0F0);

    set_width(6'd33);
    send_data(rand_word());

    // Random sections, mostly data words with palette updates, section starts and reserved ops mixed in.
    for (int p = 0; p < 16; p++) begin
      src_idle_on  = (p % 4) < 2;
      sink_idle_on = (p % 2) == 0;
      set_width(PHASE_WIDTHS[p]);
      send_item(OP_START, rand_slot(), $urandom, rand_word());
      for (int k = 0; k < 9; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)
          send_data(next_data_word());
        else if (pick < 86)
          send_item(OP_PAL_WR, rand_slot(), $urandom, rand_word());
        else if (pick < 93)
          send_item(OP_START, rand_slot(), $urandom, rand_word());
        else
          send_item(OP_RSVD, rand_slot(), $urandom, rand_word());
      end
    end

    // Closing section: the result side holds off for a long stretch at its
    // start, so the input backs up while words keep coming.
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    set_width(6'd4);
    send_item(OP_START, rand_slot(), $urandom, rand_word());
    hold_request = 1'b1;
    repeat (20) send_data(next_data_word());
    send_item(OP_START, rand_slot(), $urandom, rand_word());
    repeat (2) send_data(next_data_word());

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    sb.close_out();
    $display("Sent %0d input words across %0d width settings; checked %0d fields.",
             sb.words_seen, widths_written, sb.fields_checked);
    $display("Fields past the section limit: %0d; mismatches: %0d.",
             sb.overflow_fields, sb.errors);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
